@@ sv/bounded_deque_with_sorted_insert_defines.svh @@
// assertion helpers shared by the rtl
`ifndef BOUNDED_DEQUE_WITH_SORTED_INSERT_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SORTED_INSERT_DEFINES_SVH

// condition must hold at every clock edge outside reset
`define BDSI_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

// antecedent implies consequent in the same cycle
`define BDSI_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

@@ sv/bdsi_pkg.sv @@
`default_nettype none

package bdsi_pkg;

  localparam int unsigned OP_W          = 3;
  localparam int unsigned VALUE_FIELD_W = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned COUNT_FIELD_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_INSERT     = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // how a cell decides whether it is the target position
  typedef enum logic [2:0] {
    MODE_NONE    = 3'd0,
    MODE_ALL     = 3'd1,
    MODE_EMPTY   = 3'd2,
    MODE_LAST    = 3'd3,
    MODE_GREATER = 3'd4,
    MODE_EQUAL   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_GROW   = 2'd1,
    ACT_SHRINK = 2'd2
  } act_t;

  typedef struct packed {
    act_t  act;
    mode_t mode;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/bdsi_channels.sv @@
`default_nettype none

interface bdsi_req_if;
  logic                                valid;
  logic                                ready;
  logic [bdsi_pkg::OP_W-1:0]           operation;
  logic signed [bdsi_pkg::VALUE_FIELD_W-1:0] operand_value;

  modport source (output valid, output operation, output operand_value, input ready);
  modport sink   (input valid, input operation, input operand_value, output ready);
endinterface

interface bdsi_res_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [bdsi_pkg::VALUE_FIELD_W-1:0] result_value;
  logic                                      result_valid;
  logic [bdsi_pkg::STATUS_W-1:0]             status;
  logic [bdsi_pkg::COUNT_FIELD_W-1:0]        entry_count;

  modport source (output valid, output result_value, output result_valid,
                  output status, output entry_count, input ready);
  modport sink   (input valid, input result_value, input result_valid,
                  input status, input entry_count, output ready);
endinterface

`default_nettype wire

@@ sv/bdsi_cell.sv @@
`default_nettype none

module bdsi_cell #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire bdsi_pkg::cell_ctrl_t   ctrl,
  input  wire logic [VALUE_WIDTH-1:0] operand,
  input  wire logic [VALUE_WIDTH-1:0] left_entry,
  input  wire logic [VALUE_WIDTH-1:0] right_entry,
  input  wire logic                   left_occ,
  input  wire logic                   right_occ,
  input  wire logic                   hit_in,
  output logic                        hit_out,
  input  wire logic [VALUE_WIDTH-1:0] take_in,
  output logic [VALUE_WIDTH-1:0]      take_out,
  output logic [VALUE_WIDTH-1:0]      entry,
  output logic                        occ
);

  logic hit;
  logic sel;

  always_comb begin
    unique case (ctrl.mode)
      bdsi_pkg::MODE_ALL:     hit = 1'b1;
      bdsi_pkg::MODE_EMPTY:   hit = !occ;
      bdsi_pkg::MODE_LAST:    hit = !right_occ;
      bdsi_pkg::MODE_GREATER: hit = !occ || ($signed(entry) > $signed(operand));
      bdsi_pkg::MODE_EQUAL:   hit = occ && (entry == operand);
      default:                hit = 1'b0;
    endcase
  end

  // first hit along the chain marks the target position
  assign sel      = hit && !hit_in;
  assign hit_out  = hit_in || hit;
  assign take_out = take_in | (sel ? entry : '0);

  // occupancy is a thermometer: grow shifts a one in from the front
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.act == bdsi_pkg::ACT_GROW) begin
      occ <= left_occ;
    end else if (ctrl.act == bdsi_pkg::ACT_SHRINK) begin
      occ <= right_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.act == bdsi_pkg::ACT_GROW) begin
      if (sel) begin
        entry <= operand;
      end else if (hit_in) begin
        entry <= left_entry;
      end
    end else if (ctrl.act == bdsi_pkg::ACT_SHRINK) begin
      if (hit_out) begin
        entry <= right_entry;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/bounded_deque_with_sorted_insert.sv @@
// bounded double-ended queue with sorted insert
// req channel: one operation per transaction (operation code and operand);
// push back, push front, pop front, pop back, remove first match of a key,
// and sorted insert after every entry less than or equal to the value.
// res channel: one transaction per operation with the removed value and
// its valid flag, a status code (ok, empty, not found, full) and the count
// held afterwards.
// the list lives in a row of CAPACITY cells; each cell compares the operand
// with its own entry and shifts towards a neighbour in the same cycle, so an
// operation completes as it is accepted and the result is registered: res is
// valid in the cycle after req acceptance, throughput one operation per
// cycle while res is not stalled. the single path through the cell row
// (target search and shift) sets that throughput.
// req.ready is high while the result register is empty or being taken, so
// a stalled receiver holds the result and back-pressures req after one item.
// reset empties the list and drops any pending result; no clearing pass is
// needed, entries are only read once written.
`default_nettype none

`include "bounded_deque_with_sorted_insert_defines.svh"

module bounded_deque_with_sorted_insert #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  bdsi_req_if.sink    req,
  bdsi_res_if.source  res
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic                   fire;
  logic                   full;
  logic                   empty;
  logic                   found;
  bdsi_pkg::op_t          op;
  bdsi_pkg::mode_t        mode;
  bdsi_pkg::act_t         act;
  bdsi_pkg::status_t      status_next;
  bdsi_pkg::cell_ctrl_t   ctrl;
  logic [VALUE_WIDTH-1:0] operand;
  logic [VALUE_WIDTH-1:0] taken;

  logic [VALUE_WIDTH-1:0] ent  [CAPACITY];
  logic [CAPACITY-1:0]    occ_vec;
  logic [CAPACITY:0]      hit_chain;
  logic [VALUE_WIDTH-1:0] take_chain [CAPACITY+1];

  assign req.ready = !res.valid || res.ready;
  assign fire      = req.valid && req.ready;
  assign op        = bdsi_pkg::op_t'(req.operation);
  assign operand   = VALUE_WIDTH'($unsigned(req.operand_value));
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign found     = hit_chain[CAPACITY];
  assign taken     = take_chain[CAPACITY];

  always_comb begin
    unique case (op)
      bdsi_pkg::OP_PUSH_BACK:  mode = bdsi_pkg::MODE_EMPTY;
      bdsi_pkg::OP_PUSH_FRONT: mode = bdsi_pkg::MODE_ALL;
      bdsi_pkg::OP_POP_FRONT:  mode = bdsi_pkg::MODE_ALL;
      bdsi_pkg::OP_POP_BACK:   mode = bdsi_pkg::MODE_LAST;
      bdsi_pkg::OP_REMOVE:     mode = bdsi_pkg::MODE_EQUAL;
      bdsi_pkg::OP_INSERT:     mode = bdsi_pkg::MODE_GREATER;
      default:                 mode = bdsi_pkg::MODE_NONE;
    endcase
  end

  always_comb begin
    act         = bdsi_pkg::ACT_HOLD;
    status_next = bdsi_pkg::ST_OK;
    unique case (op) inside
      bdsi_pkg::OP_PUSH_BACK, bdsi_pkg::OP_PUSH_FRONT, bdsi_pkg::OP_INSERT: begin
        if (full) begin
          status_next = bdsi_pkg::ST_FULL;
        end else begin
          act = bdsi_pkg::ACT_GROW;
        end
      end
      bdsi_pkg::OP_POP_FRONT, bdsi_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_next = bdsi_pkg::ST_EMPTY;
        end else begin
          act = bdsi_pkg::ACT_SHRINK;
        end
      end
      bdsi_pkg::OP_REMOVE: begin
        if (empty) begin
          status_next = bdsi_pkg::ST_EMPTY;
        end else if (!found) begin
          status_next = bdsi_pkg::ST_NOT_FOUND;
        end else begin
          act = bdsi_pkg::ACT_SHRINK;
        end
      end
      default: begin
        act = bdsi_pkg::ACT_HOLD;
      end
    endcase
  end

  assign ctrl.mode = mode;
  assign ctrl.act  = fire ? act : bdsi_pkg::ACT_HOLD;

  always_comb begin
    count_next = count;
    if (act == bdsi_pkg::ACT_GROW) begin
      count_next = count + CW'(1);
    end else if (act == bdsi_pkg::ACT_SHRINK) begin
      count_next = count - CW'(1);
    end
  end

  assign hit_chain[0]  = 1'b0;
  assign take_chain[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_entry;
    logic [VALUE_WIDTH-1:0] right_entry;
    logic                   left_occ;
    logic                   right_occ;

    if (i == 0) begin : g_front
      assign left_entry = '0;
      assign left_occ   = 1'b1;
    end else begin : g_inner_l
      assign left_entry = ent[i-1];
      assign left_occ   = occ_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign right_entry = '0;
      assign right_occ   = 1'b0;
    end else begin : g_inner_r
      assign right_entry = ent[i+1];
      assign right_occ   = occ_vec[i+1];
    end

    bdsi_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .operand    (operand),
      .left_entry (left_entry),
      .right_entry(right_entry),
      .left_occ   (left_occ),
      .right_occ  (right_occ),
      .hit_in     (hit_chain[i]),
      .hit_out    (hit_chain[i+1]),
      .take_in    (take_chain[i]),
      .take_out   (take_chain[i+1]),
      .entry      (ent[i]),
      .occ        (occ_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (fire) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.result_valid <= (act == bdsi_pkg::ACT_SHRINK);
      res.result_value <= (act == bdsi_pkg::ACT_SHRINK) ?
                          bdsi_pkg::VALUE_FIELD_W'($signed(taken)) : '0;
      res.status       <= status_next;
      res.entry_count  <= bdsi_pkg::COUNT_FIELD_W'(count_next);
    end
  end

  `BDSI_ASSERT_ALWAYS(a_count_bound, count <= CW'(CAPACITY))
  `BDSI_ASSERT_ALWAYS(a_thermo_count, $countones(occ_vec) == 32'(count))
  `BDSI_ASSERT_ALWAYS(a_front_occ, occ_vec[0] == (count != '0))
  `BDSI_ASSERT_IMPLY(a_res_count, res.valid,
                     res.entry_count == bdsi_pkg::COUNT_FIELD_W'(count))
  `BDSI_ASSERT_IMPLY(a_full_refused, res.valid && res.status == bdsi_pkg::ST_FULL,
                     count == CW'(CAPACITY) && !res.result_valid)

endmodule

`default_nettype wire
